>>> sv/lzfd_pkg.sv
package lzfd_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       frame_end;
        logic       last;
    } out_item_t;

    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [1:0] KIND_BYTE       = 2'd0;
    localparam logic [1:0] KIND_CORRUPT    = 2'd1;
    localparam logic [1:0] KIND_INCOMPLETE = 2'd2;
    localparam logic [1:0] KIND_DONE       = 2'd3;

    localparam logic [2:0]  HDR_BYTES   = 3'd4;
    localparam logic [15:0] MAX_PAYLOAD = 16'd4352;
    localparam logic [3:0]  MATCH_BIAS  = 4'd3;

endpackage

>>> sv/lzfd_hist_ram.sv
module lzfd_hist_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    // Write-first: a read of the entry being written returns the new byte.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

endmodule

>>> sv/lzfd_decoder.sv
module lzfd_decoder #(
    parameter int BLOCK_BYTES = 4096,
    parameter int AW          = 12,
    parameter int CW          = 13
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  lzfd_pkg::in_item_t item,
    input  logic              room,
    output logic              emit,
    output lzfd_pkg::out_item_t emit_item,
    output logic              hist_we,
    output logic [AW-1:0]     hist_waddr,
    output logic [7:0]        hist_wdata,
    output logic              hist_re,
    output logic [AW-1:0]     hist_raddr,
    input  logic [7:0]        hist_rdata
);

    import lzfd_pkg::*;

    localparam logic [16:0] RAW_LIMIT = 17'(BLOCK_BYTES);

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_BYTE, S_MATCH, S_NOTE} state_t;
    typedef enum logic [1:0] {PH_TOKEN, PH_LITERAL, PH_OFFSET} phase_t;

    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    in_item_t        item_reg, item_next;
    logic [2:0]      hdr_cnt_reg, hdr_cnt_next;
    logic [15:0]     raw_len_reg, raw_len_next;
    logic [15:0]     pay_len_reg, pay_len_next;
    logic [15:0]     pay_cnt_reg, pay_cnt_next;
    logic [CW-1:0]   out_cnt_reg, out_cnt_next;
    logic [7:0]      lit_left_reg, lit_left_next;
    logic [3:0]      match_len_reg, match_len_next;
    logic [3:0]      off_hi_reg, off_hi_next;
    logic            stored_reg, stored_next;
    logic            corrupt_reg, corrupt_next;
    logic            rd_pend_reg, rd_pend_next;
    logic [3:0]      copy_left_reg, copy_left_next;
    logic [11:0]     off_reg, off_next;
    logic [1:0]      note_kind_reg, note_kind_next;
    logic            frame_fin_reg, frame_fin_next;
    logic            bad_after_reg, bad_after_next;

    logic [16:0]     oc17;
    logic [16:0]     rd_addr17;

    assign item_stall = (state_reg != S_IDLE);
    assign oc17       = 17'(out_cnt_reg);
    // Source of the next copy byte: the write pointer less the offset, one further on once a read is in flight.
    assign rd_addr17  = oc17 + {16'd0, rd_pend_reg} - {5'd0, off_reg};

    always_comb
    begin
        logic [7:0]  b;
        logic [16:0] pc1;
        logic [16:0] pl17;
        logic [16:0] raw17;
        logic [7:0]  lit_n;
        logic [11:0] off12;
        logic [15:0] hdr_pl;
        logic [16:0] oc_after;
        logic        pay_end;
        logic        bad;
        logic        end_bad;
        logic        emit_one;
        logic        copy;
        logic        last1;

        b        = item_reg.in_byte;
        pc1      = {1'b0, pay_cnt_reg} + 17'd1;
        pl17     = {1'b0, pay_len_reg};
        raw17    = {1'b0, raw_len_reg};
        lit_n    = {1'b0, b[6:0]} + 8'd1;
        off12    = {off_hi_reg, b};
        hdr_pl   = {b, pay_len_reg[7:0]};
        pay_end  = (pc1 >= pl17);
        oc_after = oc17;
        bad      = 1'b0;
        end_bad  = 1'b0;
        emit_one = 1'b0;
        copy     = 1'b0;
        last1    = (copy_left_reg == 4'd1);

        state_next     = state_reg;
        phase_next     = phase_reg;
        item_next      = item_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        raw_len_next   = raw_len_reg;
        pay_len_next   = pay_len_reg;
        pay_cnt_next   = pay_cnt_reg;
        out_cnt_next   = out_cnt_reg;
        lit_left_next  = lit_left_reg;
        match_len_next = match_len_reg;
        off_hi_next    = off_hi_reg;
        stored_next    = stored_reg;
        corrupt_next   = corrupt_reg;
        rd_pend_next   = rd_pend_reg;
        copy_left_next = copy_left_reg;
        off_next       = off_reg;
        note_kind_next = note_kind_reg;
        frame_fin_next = frame_fin_reg;
        bad_after_next = bad_after_reg;

        emit       = 1'b0;
        emit_item  = '0;
        hist_we    = 1'b0;
        hist_waddr = out_cnt_reg[AW-1:0];
        hist_wdata = item_reg.in_byte;
        hist_re    = 1'b0;
        hist_raddr = rd_addr17[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                if (corrupt_reg)
                begin
                    note_kind_next = KIND_CORRUPT;
                    state_next     = S_NOTE;
                end
                else if (item_reg.cmd == CMD_FINISH)
                begin
                    note_kind_next = (hdr_cnt_reg == 3'd0) ? KIND_DONE : KIND_INCOMPLETE;
                    state_next     = S_NOTE;
                end
                else if (hdr_cnt_reg < HDR_BYTES)
                begin
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    state_next   = S_IDLE;
                    unique case (hdr_cnt_reg[1:0])
                        2'd0: raw_len_next = {8'd0, b};
                        2'd1: raw_len_next = {b, raw_len_reg[7:0]};
                        2'd2: pay_len_next = {8'd0, b};
                        2'd3:
                        begin
                            pay_len_next = hdr_pl;
                            pay_cnt_next = '0;
                            out_cnt_next = '0;
                            phase_next   = PH_TOKEN;
                            stored_next  = (hdr_pl == 16'd0);
                            if (raw17 > RAW_LIMIT || hdr_pl > MAX_PAYLOAD)
                            begin
                                corrupt_next   = 1'b1;
                                note_kind_next = KIND_CORRUPT;
                                state_next     = S_NOTE;
                            end
                            else if (hdr_pl == 16'd0)
                            begin
                                pay_len_next = raw_len_reg;
                                // Empty stored frame: close it right here.
                                if (raw_len_reg == 16'd0)
                                begin
                                    hdr_cnt_next = '0;
                                    raw_len_next = '0;
                                    pay_len_next = '0;
                                    stored_next  = 1'b0;
                                end
                            end
                        end
                    endcase
                end
                else
                begin
                    pay_cnt_next = pc1[15:0];
                    if (stored_reg)
                    begin
                        emit_one = 1'b1;
                        oc_after = oc17 + 17'd1;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_TOKEN:
                            begin
                                if (!b[7])
                                begin
                                    if ((pc1 + 17'(lit_n) > pl17) || (oc17 + 17'(lit_n) > raw17))
                                    begin
                                        bad = 1'b1;
                                    end
                                    else
                                    begin
                                        lit_left_next = lit_n;
                                        phase_next    = PH_LITERAL;
                                    end
                                end
                                else if (pay_end)
                                begin
                                    bad = 1'b1;
                                end
                                else
                                begin
                                    match_len_next = {1'b0, b[6:4]} + MATCH_BIAS;
                                    off_hi_next    = b[3:0];
                                    phase_next     = PH_OFFSET;
                                end
                            end
                            PH_LITERAL:
                            begin
                                emit_one      = 1'b1;
                                oc_after      = oc17 + 17'd1;
                                lit_left_next = lit_left_reg - 8'd1;
                                if (lit_left_reg == 8'd1)
                                begin
                                    phase_next = PH_TOKEN;
                                end
                            end
                            PH_OFFSET:
                            begin
                                if ((off12 == 12'd0) || ({5'd0, off12} > oc17) ||
                                    (oc17 + 17'(match_len_reg) > raw17))
                                begin
                                    bad = 1'b1;
                                end
                                else
                                begin
                                    copy       = 1'b1;
                                    oc_after   = oc17 + 17'(match_len_reg);
                                    phase_next = PH_TOKEN;
                                end
                            end
                            default:
                            begin
                                bad = 1'b1;
                            end
                        endcase
                    end

                    frame_fin_next = 1'b0;
                    if (!bad && pay_end)
                    begin
                        if ((oc_after != raw17) || (phase_next != PH_TOKEN))
                        begin
                            end_bad = 1'b1;
                        end
                        else
                        begin
                            frame_fin_next = 1'b1;
                            hdr_cnt_next   = '0;
                            raw_len_next   = '0;
                            pay_len_next   = '0;
                            pay_cnt_next   = '0;
                            phase_next     = PH_TOKEN;
                            stored_next    = 1'b0;
                        end
                    end

                    bad_after_next = end_bad;
                    if (bad || end_bad)
                    begin
                        corrupt_next   = 1'b1;
                        note_kind_next = KIND_CORRUPT;
                    end

                    copy_left_next = match_len_reg;
                    off_next       = off12;
                    rd_pend_next   = 1'b0;

                    if (emit_one)
                    begin
                        state_next = S_BYTE;
                    end
                    else if (copy)
                    begin
                        state_next = S_MATCH;
                    end
                    else if (bad || end_bad)
                    begin
                        state_next = S_NOTE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_BYTE:
            begin
                if (room)
                begin
                    emit         = 1'b1;
                    emit_item    = '{out_byte: item_reg.in_byte, kind: KIND_BYTE,
                                     frame_end: frame_fin_reg, last: !bad_after_reg};
                    hist_we      = 1'b1;
                    out_cnt_next = out_cnt_reg + CW'(1);
                    state_next   = bad_after_reg ? S_NOTE : S_IDLE;
                end
            end

            S_MATCH:
            begin
                if (!rd_pend_reg)
                begin
                    hist_re      = 1'b1;
                    rd_pend_next = 1'b1;
                end
                else if (room)
                begin
                    emit           = 1'b1;
                    emit_item      = '{out_byte: hist_rdata, kind: KIND_BYTE,
                                       frame_end: frame_fin_reg && last1,
                                       last: last1 && !bad_after_reg};
                    hist_we        = 1'b1;
                    hist_wdata     = hist_rdata;
                    out_cnt_next   = out_cnt_reg + CW'(1);
                    copy_left_next = copy_left_reg - 4'd1;
                    if (!last1)
                    begin
                        hist_re = 1'b1;
                    end
                    else
                    begin
                        rd_pend_next = 1'b0;
                        state_next   = bad_after_reg ? S_NOTE : S_IDLE;
                    end
                end
            end

            S_NOTE:
            begin
                if (room)
                begin
                    emit       = 1'b1;
                    emit_item  = '{out_byte: 8'd0, kind: note_kind_reg,
                                   frame_end: 1'b0, last: 1'b1};
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_TOKEN;
            hdr_cnt_reg   <= '0;
            raw_len_reg   <= '0;
            pay_len_reg   <= '0;
            pay_cnt_reg   <= '0;
            out_cnt_reg   <= '0;
            lit_left_reg  <= '0;
            match_len_reg <= '0;
            off_hi_reg    <= '0;
            stored_reg    <= 1'b0;
            corrupt_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            copy_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            raw_len_reg   <= raw_len_next;
            pay_len_reg   <= pay_len_next;
            pay_cnt_reg   <= pay_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            lit_left_reg  <= lit_left_next;
            match_len_reg <= match_len_next;
            off_hi_reg    <= off_hi_next;
            stored_reg    <= stored_next;
            corrupt_reg   <= corrupt_next;
            rd_pend_reg   <= rd_pend_next;
            copy_left_reg <= copy_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        off_reg       <= off_next;
        note_kind_reg <= note_kind_next;
        frame_fin_reg <= frame_fin_next;
        bad_after_reg <= bad_after_next;
    end

endmodule

>>> sv/lz_frame_decompressor.sv
// Framed LZ byte-token decompressor.
// Input channel (item_valid / item_stall / item): one transfer per compressed
// stream byte (cmd byte) or per end-of-stream check (cmd finish).
// Output channel (result_valid / result_stall / result): one transfer per
// decoded byte, corrupt report or finish report; last marks the final result
// of an input item and frame_end the byte that completes a frame.
// Items are worked one at a time: a header byte or token byte that yields no
// result goes through the evaluate state; a literal or stored byte also
// through the byte state, a finish or corrupt report the note state, a match
// the match state at one copied byte per cycle unless the receiver stalls,
// read from a registered history port that forwards a same-cycle write.
// A result sits in an output register; the next item is taken while it waits.
// When the receiver stalls, the decoder holds its current item until the
// output register frees up; nothing is dropped.
// Reset clears all frame state and the sticky corrupt flag; the history
// memory needs no clearing, since only bytes of the current frame are read.
module lz_frame_decompressor #(
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  lzfd_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output lzfd_pkg::out_item_t result
);

    import lzfd_pkg::*;

    localparam int AW = $clog2(BLOCK_BYTES);
    localparam int CW = $clog2(BLOCK_BYTES + 1);

    logic            result_valid_reg;
    out_item_t       result_reg;
    logic            room;
    logic            emit;
    out_item_t       emit_item;
    logic            hist_we;
    logic [AW-1:0]   hist_waddr;
    logic [7:0]      hist_wdata;
    logic            hist_re;
    logic [AW-1:0]   hist_raddr;
    logic [7:0]      hist_rdata;

    assign room         = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    lzfd_decoder #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .AW         (AW),
        .CW         (CW)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item      (item),
        .room      (room),
        .emit      (emit),
        .emit_item (emit_item),
        .hist_we   (hist_we),
        .hist_waddr(hist_waddr),
        .hist_wdata(hist_wdata),
        .hist_re   (hist_re),
        .hist_raddr(hist_raddr),
        .hist_rdata(hist_rdata)
    );

    lzfd_hist_ram #(
        .DEPTH(BLOCK_BYTES),
        .AW   (AW)
    ) u_hist_ram (
        .clk  (clk),
        .we   (hist_we),
        .waddr(hist_waddr),
        .wdata(hist_wdata),
        .re   (hist_re),
        .raddr(hist_raddr),
        .rdata(hist_rdata)
    );

    // Output register: load on emit, drop once the transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= emit_item;
        end
    end

endmodule

>>> test/lzfd_decode_check.sv
`timescale 1ns / 100ps

module lzfd_decode_check #(
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  lzfd_pkg::in_item_t  item,
    input  logic                result_valid,
    input  logic                result_stall,
    input  lzfd_pkg::out_item_t result,
    output int                  fails,
    output int                  pending,
    output int                  results_seen,
    output int                  frames_done
);

    import lzfd_pkg::*;

    typedef enum logic [1:0] {
        PH_TOKEN,
        PH_LITERAL,
        PH_OFFSET
    } phase_t;

    bit [7:0]  hist_mem [0:4095];
    int        hdr_cnt;
    int        raw_len;
    int        pay_len;
    int        pay_cnt;
    int        out_cnt;
    int        lit_left;
    int        copy_len;
    int        off_hi;
    bit        stored;
    bit        corrupt;
    phase_t    phase;

    out_item_t item_results[$];
    out_item_t decoded_q[$];

    initial begin
        fails = 0;
        pending = 0;
        results_seen = 0;
        frames_done = 0;
    end

    function automatic void add_result(input logic [7:0] value, input logic [1:0] kind);
        out_item_t r;
        r.out_byte = value;
        r.kind = kind;
        r.frame_end = 1'b0;
        r.last = 1'b0;
        item_results.push_back(r);
    endfunction

    function automatic void emit_byte(input logic [7:0] value);
        hist_mem[12'(out_cnt)] = value;
        out_cnt = (out_cnt + 1) & 'h1FFF;
        add_result(value, KIND_BYTE);
    endfunction

    function automatic void close_frame();
        hdr_cnt = 0;
        raw_len = 0;
        pay_len = 0;
        pay_cnt = 0;
        phase = PH_TOKEN;
        stored = 1'b0;
    endfunction

    // Work out every result one accepted item causes and queue them in order.
    task automatic decode_item(input in_item_t it);
        logic [7:0] b;
        int         n;
        int         off;
        bit         bad;
        out_item_t  r;
        b = it.in_byte;
        bad = 1'b0;
        item_results.delete();
        if (corrupt) begin
            add_result(8'h00, KIND_CORRUPT);
        end
        else if (it.cmd == CMD_FINISH) begin
            add_result(8'h00, (hdr_cnt == 0) ? KIND_DONE : KIND_INCOMPLETE);
        end
        else if (hdr_cnt < int'(HDR_BYTES)) begin
            case (hdr_cnt)
                0: raw_len = int'(b);
                1: raw_len = raw_len | (int'(b) << 8);
                2: pay_len = int'(b);
                default: pay_len = pay_len | (int'(b) << 8);
            endcase
            hdr_cnt++;
            if (hdr_cnt == int'(HDR_BYTES)) begin
                pay_cnt = 0;
                out_cnt = 0;
                phase = PH_TOKEN;
                stored = (pay_len == 0);
                if (raw_len > BLOCK_BYTES || pay_len > int'(MAX_PAYLOAD)) begin
                    bad = 1'b1;
                end
                else begin
                    if (stored)
                        pay_len = raw_len;
                    // empty frame: done right after the header
                    if (pay_len == 0)
                        close_frame();
                end
            end
        end
        else begin
            pay_cnt++;
            if (stored) begin
                emit_byte(b);
            end
            else if (phase == PH_TOKEN) begin
                if (!b[7]) begin
                    n = int'(b[6:0]) + 1;
                    if (pay_cnt + n > pay_len || out_cnt + n > raw_len) begin
                        bad = 1'b1;
                    end
                    else begin
                        lit_left = n;
                        phase = PH_LITERAL;
                    end
                end
                else if (pay_cnt >= pay_len) begin
                    bad = 1'b1;
                end
                else begin
                    copy_len = int'(b[6:4]) + int'(MATCH_BIAS);
                    off_hi = int'(b[3:0]);
                    phase = PH_OFFSET;
                end
            end
            else if (phase == PH_LITERAL) begin
                emit_byte(b);
                lit_left--;
                if (lit_left == 0)
                    phase = PH_TOKEN;
            end
            else begin
                off = (off_hi << 8) | int'(b);
                if (off == 0 || off > out_cnt || out_cnt + copy_len > raw_len) begin
                    bad = 1'b1;
                end
                else begin
                    // copy one byte at a time so overlapping copies repeat
                    for (int i = 0; i < copy_len; i++)
                        emit_byte(hist_mem[12'(out_cnt - off)]);
                    phase = PH_TOKEN;
                end
            end
            if (!bad && pay_cnt >= pay_len) begin
                if (out_cnt != raw_len || phase != PH_TOKEN) begin
                    bad = 1'b1;
                end
                else begin
                    if (item_results.size() > 0) begin
                        r = item_results[item_results.size() - 1];
                        r.frame_end = 1'b1;
                        item_results[item_results.size() - 1] = r;
                    end
                    close_frame();
                end
            end
        end
        if (bad) begin
            corrupt = 1'b1;
            add_result(8'h00, KIND_CORRUPT);
        end
        if (item_results.size() > 0) begin
            r = item_results[item_results.size() - 1];
            r.last = 1'b1;
            item_results[item_results.size() - 1] = r;
        end
        foreach (item_results[i])
            decoded_q.push_back(item_results[i]);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endfunction

    task automatic check_result(input out_item_t got);
        out_item_t want;
        results_seen++;
        if (decoded_q.size() == 0) begin
            $error("result with none predicted: out_byte %0h kind %0d", got.out_byte,
                   got.kind);
            fails++;
        end
        else begin
            want = decoded_q.pop_front();
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("kind", 8'(want.kind), 8'(got.kind));
            check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
            check_field("last", 8'(want.last), 8'(got.last));
            if (want.frame_end)
                frames_done++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hdr_cnt = 0;
            raw_len = 0;
            pay_len = 0;
            pay_cnt = 0;
            out_cnt = 0;
            lit_left = 0;
            copy_len = 0;
            off_hi = 0;
            stored = 1'b0;
            corrupt = 1'b0;
            phase = PH_TOKEN;
            decoded_q.delete();
            pending = 0;
        end
        else begin
            if (item_valid && !item_stall)
                decode_item(item);
            if (result_valid && !result_stall)
                check_result(result);
            pending = decoded_q.size();
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
    import lzfd_pkg::*;

    localparam int BLOCK_BYTES = 4096;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum int {
        BRK_RAW_LEN,
        BRK_PAY_LEN,
        BRK_LIT_PAYLOAD,
        BRK_LIT_RAW,
        BRK_TRAILING_MATCH,
        BRK_ZERO_OFFSET,
        BRK_FAR_OFFSET,
        BRK_MATCH_RAW,
        BRK_SHORT_OUTPUT
    } break_t;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    int        fails;
    int        pending;
    int        results_seen;
    int        frames_done;
    int        cycle_count = 0;
    int        finish_count = 0;
    int        finish_pct = 0;
    in_item_t  stream_q[$];

    lz_frame_decompressor #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    lzfd_decode_check #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) chk (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .fails(fails),
        .pending(pending),
        .results_seen(results_seen),
        .frames_done(frames_done)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
            $display("tb failed");
            $finish;
        end
    end

    function automatic logic [7:0] lit_token(input int n);
        return {1'b0, 7'(n - 1)};
    endfunction

    function automatic logic [7:0] match_token(input int len, input int off);
        return {1'b1, 3'(len - int'(MATCH_BIAS)), 4'(off >> 8)};
    endfunction

    task automatic queue_finish();
        in_item_t it;
        it.cmd = CMD_FINISH;
        it.in_byte = 8'($urandom);
        stream_q.push_back(it);
        finish_count++;
    endtask

    // Now and then slip a finish check in ahead of a stream byte.
    task automatic queue_byte(input logic [7:0] value);
        in_item_t it;
        if (finish_pct > 0 && $urandom_range(99) < finish_pct)
            queue_finish();
        it.cmd = CMD_BYTE;
        it.in_byte = value;
        stream_q.push_back(it);
    endtask

    task automatic queue_header(input int raw, input int comp);
        queue_byte(8'(raw));
        queue_byte(8'(raw >> 8));
        queue_byte(8'(comp));
        queue_byte(8'(comp >> 8));
    endtask

    // Well-formed compressed frame of the given output length.
    task automatic queue_packed_frame(input int raw, input int match_pct);
        logic [7:0] body[$];
        int         made;
        int         left;
        int         lim;
        int         n;
        int         len;
        int         off;
        made = 0;
        while (made < raw) begin
            left = raw - made;
            if (made > 0 && left >= 3 && $urandom_range(99) < match_pct) begin
                len = $urandom_range(3, (left < 10) ? left : 10);
                lim = (made < 4095) ? made : 4095;
                case ($urandom_range(3))
                    0: off = 1;
                    1: off = lim;
                    default: off = $urandom_range(1, lim);
                endcase
                body.push_back(match_token(len, off));
                body.push_back(8'(off));
                made += len;
            end
            else begin
                lim = (left < 128) ? left : 128;
                n = ($urandom_range(3) == 0) ? lim : $urandom_range(1, lim);
                body.push_back(lit_token(n));
                repeat (n) body.push_back(8'($urandom));
                made += n;
            end
        end
        queue_header(raw, body.size());
        foreach (body[i])
            queue_byte(body[i]);
    endtask

    task automatic send_item(input in_item_t it);
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
    endtask

    // Receiver: spells of no stall, light stall and heavy stall.
    initial begin
        int stall_pct;
        int span;
        result_stall <= 1'b0;
        forever begin
            case ($urandom_range(2))
                0: stall_pct = 0;
                1: stall_pct = 35;
                default: stall_pct = 85;
            endcase
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge clk);
                result_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial begin
        int     goal;
        int     big_at;
        int     sel;
        int     k;
        int     n;
        int     raw;
        int     comp;
        int     burst_left;
        int     gap;
        bit     big_done;
        break_t brk;

        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;

        // Directed opening: finishes, empty frame, stored frame, compressed frame
        // with a maximum-length match, a short overlapping match and a finish
        // while the header is partly in.
        queue_finish();
        queue_header(0, 0);
        queue_finish();
        queue_header(2, 0);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h0F);
        queue_byte(8'h00);
        queue_finish();
        queue_byte(8'h07);
        queue_byte(8'h00);
        queue_byte(lit_token(2));
        queue_byte(8'h55);
        queue_byte(8'hAA);
        queue_byte(match_token(10, 1));
        queue_byte(8'h01);
        queue_byte(match_token(3, 2));
        queue_byte(8'h02);
        queue_finish();

        // Random frames, one longer match-heavy frame somewhere among them.
        finish_pct = 3;
        big_done = 1'b0;
        goal = stream_q.size() + 350;
        big_at = stream_q.size() + $urandom_range(20, 150);
        while (stream_q.size() < goal) begin
            if (!big_done && stream_q.size() >= big_at) begin
                queue_packed_frame($urandom_range(200, 300), 85);
                big_done = 1'b1;
            end
            else begin
                sel = $urandom_range(99);
                if (sel < 10) begin
                    queue_finish();
                end
                else if (sel < 16) begin
                    queue_header(0, 0);
                end
                else if (sel < 36) begin
                    raw = $urandom_range(1, 24);
                    queue_header(raw, 0);
                    repeat (raw) queue_byte(8'($urandom));
                end
                else if (sel < 42) begin
                    queue_packed_frame($urandom_range(100, 400), 30);
                end
                else begin
                    queue_packed_frame($urandom_range(1, 40), 50);
                end
            end
        end

        // Close on one broken frame, then check that corrupt sticks.
        brk = break_t'($urandom_range(int'(BRK_SHORT_OUTPUT)));
        k = $urandom_range(1, 8);
        case (brk)
            BRK_RAW_LEN: begin
                queue_header($urandom_range(BLOCK_BYTES + 1, 65535),
                             $urandom_range(0, int'(MAX_PAYLOAD)));
            end
            BRK_PAY_LEN: begin
                queue_header($urandom_range(0, BLOCK_BYTES),
                             $urandom_range(int'(MAX_PAYLOAD) + 1, 65535));
            end
            BRK_LIT_PAYLOAD: begin
                comp = $urandom_range(1, 100);
                queue_header(BLOCK_BYTES, comp);
                queue_byte(lit_token($urandom_range(comp, 128)));
            end
            BRK_LIT_RAW: begin
                raw = $urandom_range(1, 100);
                queue_header(raw, 200);
                queue_byte(lit_token($urandom_range(raw + 1, 128)));
            end
            default: begin
                case (brk)
                    BRK_TRAILING_MATCH: queue_header(k + 10, k + 2);
                    BRK_MATCH_RAW: queue_header(k + 2, k + 3);
                    BRK_SHORT_OUTPUT: queue_header(k + $urandom_range(1, 5), k + 1);
                    default: queue_header(k + 10, k + 3);
                endcase
                queue_byte(lit_token(k));
                repeat (k) queue_byte(8'($urandom));
                case (brk)
                    BRK_TRAILING_MATCH: begin
                        queue_byte(match_token($urandom_range(3, 10), 1));
                    end
                    BRK_ZERO_OFFSET: begin
                        queue_byte(match_token(3, 0));
                        queue_byte(8'h00);
                    end
                    BRK_FAR_OFFSET: begin
                        n = $urandom_range(k + 1, 4095);
                        queue_byte(match_token(3, n));
                        queue_byte(8'(n));
                    end
                    BRK_MATCH_RAW: begin
                        n = $urandom_range(1, k);
                        queue_byte(match_token($urandom_range(3, 10), n));
                        queue_byte(8'(n));
                    end
                    default: begin
                    end
                endcase
            end
        endcase
        repeat (6) begin
            if ($urandom_range(1) == 0)
                queue_finish();
            else
                queue_byte(8'($urandom));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender: bursts of back-to-back transfers with random gaps between.
        burst_left = 0;
        foreach (stream_q[i]) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    item_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            send_item(stream_q[i]);
            burst_left--;
        end
        item_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d items (%0d finish checks), checked %0d results over %0d frames",
                 stream_q.size(), finish_count, results_seen, frames_done);
        $display("stream closed on a broken frame of type %s", brk.name());
        if (fails == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
